[hdl/psjm_pkg.sv]
// ----------------------------------------------------------------------------
// psjm_pkg: shared types and constants of the packet sequence monitor
// Field widths, the status codes and the packet and result records that pass
// between the top level and the classifier core.
// ----------------------------------------------------------------------------
package psjm_pkg;

  // Field widths
  localparam int SEQ_BITS      = 32;
  localparam int DELAY_BITS    = 40;
  localparam int COUNT_BITS    = 32;
  localparam int GAP_BITS      = 32;
  localparam int GAP_SUM_BITS  = 48;
  localparam int JITTER_BITS   = 40;
  localparam int STATUS_BITS   = 3;

  // Classification reported with every packet
  typedef enum logic [STATUS_BITS-1:0] {
    ST_FIRST        = 3'd0,
    ST_IN_ORDER     = 3'd1,
    ST_OUT_OF_ORDER = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_CHECKSUM     = 3'd4,
    ST_DECODE       = 3'd5
  } status_t;

  // One received packet header
  typedef struct packed {
    logic [SEQ_BITS-1:0]   seq_number;
    logic                  payload_ok;
    logic                  decode_ok;
    logic                  warmup;
    logic [DELAY_BITS-1:0] delay;
  } item_t;

  // One result record
  typedef struct packed {
    status_t                 status;
    logic [GAP_BITS-1:0]     gap;
    logic [JITTER_BITS-1:0]  jitter;
    logic [COUNT_BITS-1:0]   reorder_total;
    logic [COUNT_BITS-1:0]   duplicate_total;
    logic [COUNT_BITS-1:0]   checksum_error_total;
    logic [GAP_SUM_BITS-1:0] gap_total;
  } result_t;

  // Counter increment that sticks at all ones
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (&v) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

[hdl/psjm_core.sv]
// ----------------------------------------------------------------------------
// psjm_core: packet classifier and statistics state
// Holds the reference sequence number, previous delay and the saturating
// counters. Works out the result of the presented packet combinationally and
// commits the new state when the packet moves on.
// ----------------------------------------------------------------------------
module psjm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  psjm_pkg::item_t   item,
  output psjm_pkg::result_t result
);
  import psjm_pkg::*;

  logic                    seen_first_r,  seen_first_nxt;
  logic [SEQ_BITS-1:0]     ref_seq_r,     ref_seq_nxt;
  logic [DELAY_BITS-1:0]   prev_delay_r,  prev_delay_nxt;
  logic [COUNT_BITS-1:0]   reorder_r,     reorder_nxt;
  logic [COUNT_BITS-1:0]   duplicate_r,   duplicate_nxt;
  logic [COUNT_BITS-1:0]   cksum_err_r,   cksum_err_nxt;
  logic [GAP_SUM_BITS-1:0] gap_sum_r,     gap_sum_nxt;

  logic [SEQ_BITS-1:0]     gap_full;
  logic [GAP_SUM_BITS:0]   gap_sum_ext;
  logic [GAP_SUM_BITS-1:0] gap_sum_sat;
  logic [DELAY_BITS:0]     delay_diff;
  logic [DELAY_BITS:0]     delay_abs;
  status_t                 status;
  logic [GAP_BITS-1:0]     gap;
  logic [JITTER_BITS-1:0]  jitter;

  // Gap to the reference and the saturating running sum
  assign gap_full    = item.seq_number - ref_seq_r - 1'b1;
  assign gap_sum_ext = {1'b0, gap_sum_r} + (GAP_SUM_BITS + 1)'(gap_full);
  assign gap_sum_sat = gap_sum_ext[GAP_SUM_BITS] ? {GAP_SUM_BITS{1'b1}}
                                                 : gap_sum_ext[GAP_SUM_BITS-1:0];

  // Absolute delay change on one extra bit so that it cannot overflow
  assign delay_diff = {item.delay[DELAY_BITS-1], item.delay}
                    - {prev_delay_r[DELAY_BITS-1], prev_delay_r};
  assign delay_abs  = delay_diff[DELAY_BITS] ? (~delay_diff + 1'b1) : delay_diff;

  // Classification and next state
  always_comb begin
    seen_first_nxt = seen_first_r;
    ref_seq_nxt    = ref_seq_r;
    prev_delay_nxt = prev_delay_r;
    reorder_nxt    = reorder_r;
    duplicate_nxt  = duplicate_r;
    cksum_err_nxt  = cksum_err_r;
    gap_sum_nxt    = gap_sum_r;
    gap            = '0;
    jitter         = '0;
    if (!item.payload_ok) begin
      cksum_err_nxt = sat_inc(cksum_err_r);
      status        = ST_CHECKSUM;
    end else if (!item.decode_ok) begin
      status = ST_DECODE;
    end else begin
      if (!seen_first_r) begin
        seen_first_nxt = 1'b1;
        ref_seq_nxt    = item.seq_number;
        status         = ST_FIRST;
      end else if (item.seq_number < ref_seq_r) begin
        reorder_nxt = sat_inc(reorder_r);
        status      = ST_OUT_OF_ORDER;
      end else if (item.seq_number == ref_seq_r) begin
        duplicate_nxt = sat_inc(duplicate_r);
        status        = ST_DUPLICATE;
      end else begin
        gap         = GAP_BITS'(gap_full);
        gap_sum_nxt = gap_sum_sat;
        ref_seq_nxt = item.seq_number;
        status      = ST_IN_ORDER;
      end
      if (!item.warmup) begin
        jitter         = JITTER_BITS'(delay_abs);
        prev_delay_nxt = item.delay;
      end
    end
  end

  // Result carries the totals after this packet
  always_comb begin
    result.status               = status;
    result.gap                  = gap;
    result.jitter               = jitter;
    result.reorder_total        = reorder_nxt;
    result.duplicate_total      = duplicate_nxt;
    result.checksum_error_total = cksum_err_nxt;
    result.gap_total            = gap_sum_nxt;
  end

  // State registers, committed when the packet leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r <= 1'b0;
      ref_seq_r    <= '0;
      prev_delay_r <= '0;
      reorder_r    <= '0;
      duplicate_r  <= '0;
      cksum_err_r  <= '0;
      gap_sum_r    <= '0;
    end else if (fire) begin
      seen_first_r <= seen_first_nxt;
      ref_seq_r    <= ref_seq_nxt;
      prev_delay_r <= prev_delay_nxt;
      reorder_r    <= reorder_nxt;
      duplicate_r  <= duplicate_nxt;
      cksum_err_r  <= cksum_err_nxt;
      gap_sum_r    <= gap_sum_nxt;
    end
  end

  // The first-packet class can only be given once after reset.
  a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
    fire && seen_first_r |-> status != ST_FIRST)
    else $error("first-packet status given twice");

  // The gap sum never shrinks.
  a_gap_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> gap_sum_r >= $past(gap_sum_r))
    else $error("gap sum decreased");

  // The reference only moves on a first or in-order packet.
  a_ref_move: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !(status == ST_FIRST || status == ST_IN_ORDER) |=> $stable(ref_seq_r))
    else $error("reference changed on a non-advancing packet");

endmodule

[hdl/packet_sequence_and_jitter_monitor.sv]
// ----------------------------------------------------------------------------
// packet_sequence_and_jitter_monitor: sequence and jitter monitor top level
// Input stage, classifier core and result register with valid/ready handshake.
// ----------------------------------------------------------------------------
// Usage
//   Each transfer on the in_ channel carries one packet header: sequence
//   number, checksum and decode flags, warmup flag and signed delay. Each one
//   gives exactly one transfer on the out_ channel, in order: status, gap,
//   jitter and the running totals after that packet.
//   The packet is captured in an input register, classified by combinational
//   logic and written to the result register, which raises out_valid. One
//   packet per cycle is sustained while out_ready is high; the rate is set by
//   the single classifier pass between the two registers.
//   If the receiver holds out_ready low, the result waits in the result
//   register and one further packet is taken into the input register; after
//   that in_ready drops until the result is taken.
//   Reset clears both stages, the reference sequence number, the previous
//   delay and all counters; the next good packet is reported as the first.
// ----------------------------------------------------------------------------
module packet_sequence_and_jitter_monitor (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [psjm_pkg::SEQ_BITS-1:0]            in_seq_number,
  input  logic                                     in_payload_ok,
  input  logic                                     in_decode_ok,
  input  logic                                     in_warmup,
  input  logic signed [psjm_pkg::DELAY_BITS-1:0]   in_delay,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [psjm_pkg::STATUS_BITS-1:0]         out_status,
  output logic [psjm_pkg::GAP_BITS-1:0]            out_gap,
  output logic [psjm_pkg::JITTER_BITS-1:0]         out_jitter,
  output logic [psjm_pkg::COUNT_BITS-1:0]          out_reorder_total,
  output logic [psjm_pkg::COUNT_BITS-1:0]          out_duplicate_total,
  output logic [psjm_pkg::COUNT_BITS-1:0]          out_checksum_error_total,
  output logic [psjm_pkg::GAP_SUM_BITS-1:0]        out_gap_total
);
  import psjm_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t result_r;
  result_t core_result;
  logic    advance;
  logic    in_take;

  // Handshake: the input stage moves on whenever the result register is free or being read
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.seq_number <= in_seq_number;
      s1_item_r.payload_ok <= in_payload_ok;
      s1_item_r.decode_ok  <= in_decode_ok;
      s1_item_r.warmup     <= in_warmup;
      s1_item_r.delay      <= in_delay;
    end
  end

  // Classifier and statistics
  psjm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= core_result;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = result_r.status;
  assign out_gap                  = result_r.gap;
  assign out_jitter               = result_r.jitter;
  assign out_reorder_total        = result_r.reorder_total;
  assign out_duplicate_total      = result_r.duplicate_total;
  assign out_checksum_error_total = result_r.checksum_error_total;
  assign out_gap_total            = result_r.gap_total;

  // Only the defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DECODE)
    else $error("undefined status code");

  // A non-zero gap belongs to an in-order packet.
  a_gap_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gap != '0 |-> out_status == ST_IN_ORDER)
    else $error("gap reported on a packet that is not in order");

  // Rejected packets carry no jitter.
  a_jitter_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CHECKSUM || out_status == ST_DECODE) |->
    out_jitter == '0)
    else $error("jitter reported on a rejected packet");

endmodule
